FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked on aclk, ignored while aresetn is low.
`define AOQT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked on aclk, also checked during reset.
`define AOQT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define AOQT_ASSERT(lbl, prop, msg)
`define AOQT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/aoqt_pkg.sv
// Shared types and constants of the box overlap query table.
package aoqt_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ID_W            = 6;
    localparam int COORD_W         = 32;
    localparam int CMD_W           = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } box_t;

    // Per-cell control: ins/rem are decoded per entry, load/shift are broadcast.
    typedef struct packed {
        logic ins;
        logic rem;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

FILE: rtl/aoqt_cell.sv
// One table entry: stored box, present flag, overlap test and a hit shift stage.
module aoqt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  aoqt_pkg::cell_ctrl_t ctrl,
    input  aoqt_pkg::box_t      wr_box,
    input  aoqt_pkg::box_t      qry_box,
    input  logic                hit_in,
    output logic                hit_out,
    output logic                present_out
);

    aoqt_pkg::box_t box_reg;
    logic           present_reg;
    logic           present_next;
    logic           hit_reg;
    logic           hit_next;
    logic           overlap;

    // closed intervals, all three axes
    assign overlap = !(box_reg.lo_x > qry_box.hi_x || qry_box.lo_x > box_reg.hi_x)
                  && !(box_reg.lo_y > qry_box.hi_y || qry_box.lo_y > box_reg.hi_y)
                  && !(box_reg.lo_z > qry_box.hi_z || qry_box.lo_z > box_reg.hi_z);

    always_comb begin
        present_next = present_reg;
        if (ctrl.ins) begin
            present_next = 1'b1;
        end else if (ctrl.rem) begin
            present_next = 1'b0;
        end
    end

    always_comb begin
        hit_next = hit_reg;
        if (ctrl.load) begin
            hit_next = present_reg && overlap;
        end else if (ctrl.shift) begin
            hit_next = hit_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            present_reg <= present_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ins) begin
            box_reg <= wr_box;
        end
    end

    assign hit_out     = hit_reg;
    assign present_out = present_reg;

endmodule

FILE: rtl/aoqt_top_dummy_guard.sv
// Hit chain bookkeeping: scan position, shift and done control, and the hit id.
module aoqt_scan #(
    parameter int MAX_ENTRIES = aoqt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        hit_head,
    input  logic                        hits_above,
    input  logic                        scan_en,
    input  logic                        out_ready,
    output logic                        shift,
    output logic                        done,
    output logic [aoqt_pkg::ID_W-1:0]   hit_id
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;

    // a hit needs a free output slot; an empty position is skipped at once
    assign shift  = scan_en && (hit_head ? out_ready : hits_above);
    assign done   = scan_en && out_ready && !hits_above;
    assign hit_id = aoqt_pkg::ID_W'(pos_reg);

    always_comb begin
        pos_next = pos_reg;
        if (start) begin
            pos_next = '0;
        end else if (shift) begin
            pos_next = pos_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/aabb_overlap_query_table_unit.sv
// Top level of the box overlap query table: command decode, cell chain and result port.
// Box overlap query table. Each of MAX_ENTRIES cells holds one entry's box
// (signed 16.16 bounds) and present flag. Insert (cmd 0) writes or replaces an
// entry, remove (cmd 1) clears it; both answer with a single result carrying
// was_present and last, registered on the edge that accepts the request. A
// query (cmd 2) takes the query box into a register, all cells test it in
// parallel on the next cycle and latch a hit bit, and the hit bits then shift
// down the cell chain one position per cycle toward cell 0, except while a hit
// at cell 0 waits for the output register, which cell 0 feeds. Hits leave in
// ascending id order, one at a time, held while the result side stalls. With
// no hits a single all-zero result with last set is returned. cmd 3 answers
// with one result that has only last set. s_ready is high only while no query
// is in progress and the output register is free or being drained. Entry ids
// at or above MAX_ENTRIES change nothing and report was_present 0.
`include "assert_macros.svh"

module aabb_overlap_query_table_unit #(
    parameter int MAX_ENTRIES = aoqt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [aoqt_pkg::CMD_W-1:0]             s_cmd,
    input  logic [aoqt_pkg::ID_W-1:0]              s_entry_id,
    input  logic signed [aoqt_pkg::COORD_W-1:0]    s_box_min_x,
    input  logic signed [aoqt_pkg::COORD_W-1:0]    s_box_min_y,
    input  logic signed [aoqt_pkg::COORD_W-1:0]    s_box_min_z,
    input  logic signed [aoqt_pkg::COORD_W-1:0]    s_box_max_x,
    input  logic signed [aoqt_pkg::COORD_W-1:0]    s_box_max_y,
    input  logic signed [aoqt_pkg::COORD_W-1:0]    s_box_max_z,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [aoqt_pkg::ID_W-1:0]              m_hit_id,
    output logic                                   m_hit_valid,
    output logic                                   m_was_present,
    output logic                                   m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    aoqt_pkg::box_t in_box;
    aoqt_pkg::box_t qry_box_reg;

    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] present_vec;
    logic [MAX_ENTRIES-1:0] sel_vec;

    logic accept;
    logic slot_free;
    logic is_write;
    logic was_present;
    logic hits_above;
    logic scan_shift;
    logic scan_done;
    logic [aoqt_pkg::ID_W-1:0] scan_id;

    // output register
    logic                      m_valid_reg,       m_valid_next;
    logic [aoqt_pkg::ID_W-1:0] m_hit_id_reg,      m_hit_id_next;
    logic                      m_hit_valid_reg,   m_hit_valid_next;
    logic                      m_was_present_reg, m_was_present_next;
    logic                      m_last_reg,        m_last_next;

    assign in_box = '{lo_x: s_box_min_x, lo_y: s_box_min_y, lo_z: s_box_min_z,
                      hi_x: s_box_max_x, hi_y: s_box_max_y, hi_z: s_box_max_z};

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign is_write  = (s_cmd == aoqt_pkg::CMD_INSERT) || (s_cmd == aoqt_pkg::CMD_REMOVE);

    // one-hot entry select; ids past the table select nothing
    assign was_present = |(present_vec & sel_vec);
    assign hits_above  = |(hit_vec >> 1);

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        aoqt_pkg::cell_ctrl_t ctrl;
        logic                 hit_in;

        assign sel_vec[i] = (s_entry_id == aoqt_pkg::ID_W'(i));
        assign ctrl = '{ins:   accept && (s_cmd == aoqt_pkg::CMD_INSERT) && sel_vec[i],
                        rem:   accept && (s_cmd == aoqt_pkg::CMD_REMOVE) && sel_vec[i],
                        load:  (state_reg == ST_LOAD),
                        shift: scan_shift};

        if (i == MAX_ENTRIES - 1) begin : g_end
            assign hit_in = 1'b0;
        end else begin : g_mid
            assign hit_in = hit_vec[i+1];
        end

        aoqt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .wr_box      (in_box),
            .qry_box     (qry_box_reg),
            .hit_in      (hit_in),
            .hit_out     (hit_vec[i]),
            .present_out (present_vec[i])
        );
    end

    // ---------------- scan position ----------------
    aoqt_scan #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (state_reg == ST_LOAD),
        .hit_head   (hit_vec[0]),
        .hits_above (hits_above),
        .scan_en    (state_reg == ST_SCAN),
        .out_ready  (slot_free),
        .shift      (scan_shift),
        .done       (scan_done),
        .hit_id     (scan_id)
    );

    // ---------------- control and result register ----------------
    always_comb begin
        state_next         = state_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_hit_id_next      = m_hit_id_reg;
        m_hit_valid_next   = m_hit_valid_reg;
        m_was_present_next = m_was_present_reg;
        m_last_next        = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == aoqt_pkg::CMD_QUERY) begin
                        state_next = ST_LOAD;
                    end else begin
                        // insert, remove and the unused code answer at once
                        m_valid_next       = 1'b1;
                        m_hit_id_next      = '0;
                        m_hit_valid_next   = 1'b0;
                        m_was_present_next = is_write && was_present;
                        m_last_next        = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (slot_free && (hit_vec[0] || scan_done)) begin
                    // a hit at the head, or the empty-query result
                    m_valid_next       = 1'b1;
                    m_hit_id_next      = hit_vec[0] ? scan_id : '0;
                    m_hit_valid_next   = hit_vec[0];
                    m_was_present_next = 1'b0;
                    m_last_next        = !hits_above;
                end
                if (scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        m_hit_id_reg      <= m_hit_id_next;
        m_hit_valid_reg   <= m_hit_valid_next;
        m_was_present_reg <= m_was_present_next;
        m_last_reg        <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_cmd == aoqt_pkg::CMD_QUERY)) begin
            qry_box_reg <= in_box;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit_id      = m_hit_id_reg;
    assign m_hit_valid   = m_hit_valid_reg;
    assign m_was_present = m_was_present_reg;
    assign m_last        = m_last_reg;

    // ---------------- assertions ----------------
    `AOQT_ASSERT(a_load_then_scan, (state_reg == ST_LOAD) |=> (state_reg == ST_SCAN), "load not followed by scan")
    `AOQT_ASSERT(a_no_accept_in_query, (state_reg != ST_IDLE) |-> !s_ready, "request taken during a query")
    `AOQT_ASSERT(a_hit_not_present, (m_valid && m_hit_valid) |-> !m_was_present, "hit result carries was_present")
    `AOQT_ASSERT(a_empty_query_result, ((state_reg == ST_SCAN) && (hit_vec == '0) && slot_free) |=> (m_valid && m_last && !m_hit_valid), "empty query must end with one null result")
    `AOQT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> ((state_reg == ST_IDLE) && !m_valid), "reset did not clear control")

endmodule

FILE: bench/aabb_overlap_query_table_unit_tb.sv
// Self-checking testbench for the box overlap query table: predicted results vs. DUT.
`timescale 1ns / 1ps

module aabb_overlap_query_table_unit_tb;

    // cmd 3 has no function; the block answers it with one result that has only last set
    localparam logic [aoqt_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic signed [aoqt_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [aoqt_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [aoqt_pkg::COORD_W-1:0] ONE       = 32'sh0001_0000;  // 1.0 in 16.16

    localparam int HOLD_CYCLES  = 300;                            // long result-side stall
    localparam int DRAIN_CYCLES = aoqt_pkg::MAX_ENTRIES_DEF + 8;  // longest query plus margin
    localparam int RUN_LIMIT_NS = 1_500_000;

    typedef struct packed {
        logic [aoqt_pkg::ID_W-1:0] hit_id;
        logic                      hit_valid;
        logic                      was_present;
        logic                      last;
    } result_t;

    // Mirror of the entry table; turns each accepted request into the results
    // it must produce and checks returned results against them in order.
    class box_table_checker;
        bit [aoqt_pkg::MAX_ENTRIES_DEF-1:0] occupied;
        aoqt_pkg::box_t                     boxes[aoqt_pkg::MAX_ENTRIES_DEF];
        result_t                            expected_results[$];
        int                                 mismatches;

        function new();
            occupied   = '0;
            mismatches = 0;
        endfunction

        // append at the tail of the expected queue
        function void queue_result(result_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        // closed intervals: apart only if one lies strictly beyond the other
        function bit overlaps(aoqt_pkg::box_t e, aoqt_pkg::box_t q);
            return !($signed(e.lo_x) > $signed(q.hi_x) || $signed(q.lo_x) > $signed(e.hi_x) ||
                     $signed(e.lo_y) > $signed(q.hi_y) || $signed(q.lo_y) > $signed(e.hi_y) ||
                     $signed(e.lo_z) > $signed(q.hi_z) || $signed(q.lo_z) > $signed(e.hi_z));
        endfunction

        function void take_request(logic [aoqt_pkg::CMD_W-1:0] op,
                                   logic [aoqt_pkg::ID_W-1:0] id, aoqt_pkg::box_t b);
            result_t r;
            int      hits;
            r    = '0;
            hits = 0;
            if (op == aoqt_pkg::CMD_INSERT || op == aoqt_pkg::CMD_REMOVE) begin
                r.was_present = occupied[id];
                r.last        = 1'b1;
                if (op == aoqt_pkg::CMD_INSERT) begin
                    boxes[id]    = b;
                    occupied[id] = 1'b1;
                end else begin
                    occupied[id] = 1'b0;
                end
                queue_result(r);
            end else if (op == aoqt_pkg::CMD_QUERY) begin
                for (int e = 0; e < aoqt_pkg::MAX_ENTRIES_DEF; e++) begin
                    if (occupied[e] && overlaps(boxes[e], b)) begin
                        r.hit_id    = e[aoqt_pkg::ID_W-1:0];
                        r.hit_valid = 1'b1;
                        queue_result(r);
                        hits++;
                    end
                end
                if (hits == 0) begin
                    r.last = 1'b1;
                    queue_result(r);
                end else begin
                    expected_results[$].last = 1'b1;
                end
            end else begin
                r.last = 1'b1;
                queue_result(r);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result id=%0d hit=%0b was=%0b last=%0b",
                             $realtime, got.hit_id, got.hit_valid, got.was_present, got.last);
                return;
            end
            want = expected_results.pop_front();
            if (got.hit_id !== want.hit_id || got.hit_valid !== want.hit_valid ||
                got.was_present !== want.was_present || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result mismatch, expected id=%0d hit=%0b was=%0b last=%0b,",
                              " got id=%0d hit=%0b was=%0b last=%0b"},
                             $realtime, want.hit_id, want.hit_valid, want.was_present,
                             want.last, got.hit_id, got.hit_valid, got.was_present, got.last);
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [aoqt_pkg::CMD_W-1:0]           s_cmd;
    logic [aoqt_pkg::ID_W-1:0]            s_entry_id;
    logic signed [aoqt_pkg::COORD_W-1:0]  s_box_min_x;
    logic signed [aoqt_pkg::COORD_W-1:0]  s_box_min_y;
    logic signed [aoqt_pkg::COORD_W-1:0]  s_box_min_z;
    logic signed [aoqt_pkg::COORD_W-1:0]  s_box_max_x;
    logic signed [aoqt_pkg::COORD_W-1:0]  s_box_max_y;
    logic signed [aoqt_pkg::COORD_W-1:0]  s_box_max_z;
    logic                                 m_valid;
    logic                                 m_ready;
    logic [aoqt_pkg::ID_W-1:0]            m_hit_id;
    logic                                 m_hit_valid;
    logic                                 m_was_present;
    logic                                 m_last;

    // idling controls for the request and result sides
    int unsigned send_idle_odds = 0;   // percent chance of a gap after a request
    int unsigned recv_idle_odds = 0;   // percent chance of a stall burst
    bit          quiet_tail     = 1'b0;  // no idling at all in the closing stretch
    bit          long_hold_req  = 1'b0;  // asks the result side for one long stall

    box_table_checker table_check = new();

    aabb_overlap_query_table_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_entry_id    (s_entry_id),
        .s_box_min_x   (s_box_min_x),
        .s_box_min_y   (s_box_min_y),
        .s_box_min_z   (s_box_min_z),
        .s_box_max_x   (s_box_max_x),
        .s_box_max_y   (s_box_max_y),
        .s_box_max_z   (s_box_max_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit_id      (m_hit_id),
        .m_hit_valid   (m_hit_valid),
        .m_was_present (m_was_present),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Both handshakes are observed on the rising edge, where everything driven
    // at the falling edge is settled. Results are checked before the request of
    // the same edge is noted, so a stray result can never match a fresh request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                table_check.check_result({m_hit_id, m_hit_valid, m_was_present, m_last});
            if (s_valid && s_ready)
                table_check.take_request(s_cmd, s_entry_id,
                                         {s_box_min_x, s_box_min_y, s_box_min_z,
                                          s_box_max_x, s_box_max_y, s_box_max_z});
        end
    end

    // Result side. Each pass starts at a falling edge and decides m_ready for
    // one cycle, a short stall burst, or the long stall that fills the block.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_odds) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // s_valid still high unless a random idle gap follows, so back-to-back requests keep valid.
    task automatic send_request(input logic [aoqt_pkg::CMD_W-1:0] op,
                                input logic [aoqt_pkg::ID_W-1:0] id,
                                input aoqt_pkg::box_t b);
        s_cmd       = op;
        s_entry_id  = id;
        s_box_min_x = b.lo_x;
        s_box_min_y = b.lo_y;
        s_box_min_z = b.lo_z;
        s_box_max_x = b.hi_x;
        s_box_max_y = b.hi_y;
        s_box_max_z = b.hi_z;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!quiet_tail && $urandom_range(0, 99) < send_idle_odds) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
    endtask

    function automatic aoqt_pkg::box_t cube(logic signed [aoqt_pkg::COORD_W-1:0] lo,
                                            logic signed [aoqt_pkg::COORD_W-1:0] hi);
        return {lo, lo, lo, hi, hi, hi};
    endfunction

    function automatic logic [aoqt_pkg::ID_W-1:0] pick_id();
        return aoqt_pkg::ID_W'($urandom_range(0, 63));
    endfunction

    // Mostly coordinates within +-16.0 so boxes actually meet; some full range.
    function automatic logic signed [aoqt_pkg::COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 9) < 7)
            return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        return $urandom;
    endfunction

    // Well-formed boxes with a span up to max_span, one in ten inverted.
    function automatic aoqt_pkg::box_t make_box(int unsigned max_span);
        aoqt_pkg::box_t                      b;
        logic signed [aoqt_pkg::COORD_W-1:0] lo[3];
        logic signed [aoqt_pkg::COORD_W-1:0] hi[3];
        bit                                  flip;
        flip = ($urandom_range(0, 9) == 0);
        for (int a = 0; a < 3; a++) begin
            lo[a] = pick_coord();
            hi[a] = flip ? lo[a] - $urandom_range(1, max_span)
                         : lo[a] + $urandom_range(0, max_span);
        end
        b = {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
        return b;
    endfunction

    task automatic send_random(int unsigned n);
        int unsigned roll;
        for (int i = 0; i < n; i++) begin
            // change idling density now and then; zero odds give bursts of none
            if (i % 16 == 0) begin
                send_idle_odds = $urandom_range(0, 3) * 12;
                recv_idle_odds = $urandom_range(0, 3) * 12;
            end
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_request(aoqt_pkg::CMD_INSERT, pick_id(), make_box(32'h0008_0000));
            else if (roll < 65)
                send_request(aoqt_pkg::CMD_REMOVE, pick_id(), make_box(32'h0008_0000));
            else if (roll < 95)
                send_request(aoqt_pkg::CMD_QUERY, pick_id(), make_box(32'h0010_0000));
            else
                send_request(CMD_SPARE, pick_id(), {$urandom, $urandom, $urandom,
                                                    $urandom, $urandom, $urandom});
        end
    endtask

    initial begin
        aoqt_pkg::box_t b;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cmd       = aoqt_pkg::CMD_INSERT;
        s_entry_id  = '0;
        s_box_min_x = '0;
        s_box_min_y = '0;
        s_box_min_z = '0;
        s_box_max_x = '0;
        s_box_max_y = '0;
        s_box_max_z = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // ---- directed: extremes, updates, touching and inverted boxes ----
        send_idle_odds = 25;
        recv_idle_odds = 25;
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(COORD_MIN, COORD_MAX));  // empty table
        send_request(aoqt_pkg::CMD_REMOVE, 6'd5,  cube(0, 0));                  // absent entry
        send_request(aoqt_pkg::CMD_INSERT, 6'd0,  cube(COORD_MIN, COORD_MAX));  // whole space
        send_request(aoqt_pkg::CMD_INSERT, 6'd63, cube(0, 0));                  // single point
        send_request(aoqt_pkg::CMD_INSERT, 6'd0,  cube(-ONE, ONE));             // update
        send_request(aoqt_pkg::CMD_INSERT, 6'd31, cube(5 * ONE, -5 * ONE));     // inverted
        send_request(aoqt_pkg::CMD_INSERT, 6'd42, cube(COORD_MAX, COORD_MAX));
        send_request(aoqt_pkg::CMD_INSERT, 6'd21, cube(COORD_MIN, COORD_MIN));
        send_request(aoqt_pkg::CMD_QUERY,  6'd63, cube(COORD_MIN, COORD_MAX));  // all present
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(ONE, 2 * ONE));          // upper edge
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(-2 * ONE, -ONE));        // lower edge
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(COORD_MAX, COORD_MIN));  // inverted query
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(COORD_MAX, COORD_MAX));
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(COORD_MIN, COORD_MIN));
        send_request(CMD_SPARE,            6'd63, {6{32'hFFFF_FFFF}});          // unused code
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(0, 0));                  // point query
        b      = cube(COORD_MIN, COORD_MAX);
        b.lo_x = 3 * ONE;
        b.hi_x = 4 * ONE;                                                       // apart on x
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  b);
        b      = cube(COORD_MIN, COORD_MAX);
        b.hi_z = -2 * ONE;                                                      // apart on z
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  b);
        send_request(aoqt_pkg::CMD_REMOVE, 6'd63, cube(0, 0));                  // was present
        send_request(aoqt_pkg::CMD_REMOVE, 6'd63, cube(0, 0));                  // now absent
        send_request(aoqt_pkg::CMD_QUERY,  6'd0,  cube(-ONE, ONE));

        // ---- fill every entry, then one query that hits all of them ----
        for (int id = 0; id < aoqt_pkg::MAX_ENTRIES_DEF; id++)
            send_request(aoqt_pkg::CMD_INSERT, id[aoqt_pkg::ID_W-1:0],
                         make_box(32'h0008_0000));
        send_request(aoqt_pkg::CMD_QUERY, 6'd0, cube(COORD_MIN, COORD_MAX));

        // ---- long result stall while requests keep coming: block backs up ----
        send_idle_odds = 0;
        long_hold_req  = 1'b1;
        send_request(aoqt_pkg::CMD_QUERY, 6'd0, cube(COORD_MIN, COORD_MAX));
        for (int i = 0; i < 4; i++)
            send_request(aoqt_pkg::CMD_INSERT, pick_id(), make_box(32'h0008_0000));
        send_request(aoqt_pkg::CMD_QUERY, 6'd0, make_box(32'h0010_0000));

        // ---- sender waits until every expected result is back ----
        s_valid = 1'b0;
        while (table_check.outstanding() != 0) @(negedge aclk);

        // ---- random mix with varying idling ----
        send_random(8);

        // ---- closing stretch without idling on either side ----
        quiet_tail = 1'b1;
        send_random(6);

        s_valid = 1'b0;
        while (table_check.outstanding() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (table_check.mismatches == 0 && table_check.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // generous limit: covers every query at 64 hits with the longest stalls
    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
